// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the thread slot scheduler.
// Each macro samples on posedge clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: invariant");

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: src/tsrr_pkg.sv
// Package for the thread slot round-robin scheduler: sizes, codes, payload
// and internal command structs. Used by every module of the block but tsrr_ram.
package tsrr_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int TID_W      = 8;
	localparam int WORD_W     = 32;
	localparam int SLOT_OUT_W = 6;
	localparam int PAIR_W     = 2 * WORD_W;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_YIELD  = 2'd1,
		OP_JOIN   = 2'd2,
		OP_EXIT   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_REFUSED  = 2'd1,
		STATUS_BAD_JOIN = 2'd2,
		STATUS_NO_RUN   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FREE     = 2'd0,
		SLOT_RUNNABLE = 2'd1,
		SLOT_RUNNING  = 2'd2,
		SLOT_SLEEPING = 2'd3
	} slot_state_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_CREATE_SCAN,
		SEQ_JOIN_SCAN,
		SEQ_SAVE,
		SEQ_SWITCH_SCAN,
		SEQ_FETCH,
		SEQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [WORD_W-1:0] start_address;
		logic [WORD_W-1:0] argument;
		logic [TID_W-1:0]  join_tid;
		logic [WORD_W-1:0] saved_sp;
		logic [WORD_W-1:0] saved_fp;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [TID_W-1:0]      new_tid;
		logic [TID_W-1:0]      running_tid;
		logic [SLOT_OUT_W-1:0] running_slot;
		logic                  first_run;
		logic [WORD_W-1:0]     resume_start;
		logic [WORD_W-1:0]     resume_argument;
		logic [WORD_W-1:0]     resume_sp;
		logic [WORD_W-1:0]     resume_fp;
	} out_item_t;

	// Update of the slot table: one indexed write plus a wake of all sleepers.
	typedef struct packed {
		slot_idx_t        idx;
		logic             state_en;
		slot_state_t      state_val;
		logic             tid_en;
		logic [TID_W-1:0] tid_val;
		logic             fresh_en;
		logic             fresh_val;
		logic             wake;
	} tbl_cmd_t;

	// Slot table read port.
	typedef struct packed {
		slot_state_t      state;
		logic [TID_W-1:0] tid;
		logic             fresh;
	} tbl_rd_t;

	// Advance a slot index, wrapping at the table end.
	function automatic slot_idx_t slot_inc(input slot_idx_t idx);
		slot_idx_t res;
		if (idx == SLOT_W'(SLOT_COUNT - 1)) begin
			res = '0;
		end else begin
			res = idx + 1'b1;
		end
		return res;
	endfunction

endpackage

// File: src/thread_slot_round_robin_scheduler.sv
// Round-robin thread slot scheduler, top level.
// Calls scan the slot table with the shared compare unit, which examines one slot per
// cycle. A new item is taken only once the last result is loaded into the result
// register; that register frees the input side before the result is taken.
// Reset clears slot states, tids, fresh bits, running slot and tid counter at once;
// entry and context RAM rows hold no reset value and need no clearing pass.
module thread_slot_round_robin_scheduler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsrr_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output tsrr_pkg::out_item_t out_item
);

`include "assert_macros.svh"

	logic                out_valid_q;
	tsrr_pkg::out_item_t out_item_q;
	logic                out_free;
	logic                res_valid;
	tsrr_pkg::out_item_t res_item;

	// Result register is free when empty or drained in this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	tsrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	// Load a finished result, drop it after its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_item_q <= res_item;
		end
	end

	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`ASSERT_SAME(a_result_blocks_input, res_valid, !in_ready)
	`ASSERT_NEXT(a_result_loaded, res_valid && out_free, out_valid_q)
	`ASSERT_ALWAYS(a_slot_in_range, !out_valid_q || (out_item_q.running_slot < tsrr_pkg::SLOT_COUNT))

endmodule

// File: src/tsrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds slot entry and saved context words.
module tsrr_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; hold data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/tsrr_slot_table.sv
// Slot table: per-slot state, tid and fresh bit in reset flops.
// Depends on tsrr_pkg for the command and read structs.
module tsrr_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsrr_pkg::tbl_cmd_t          cmd,
	input  tsrr_pkg::slot_idx_t         rd_idx,
	input  tsrr_pkg::slot_idx_t         cur_idx,
	output tsrr_pkg::tbl_rd_t           rd,
	output logic [tsrr_pkg::TID_W-1:0]  cur_tid
);

	tsrr_pkg::slot_state_t            state_q [tsrr_pkg::SLOT_COUNT];
	logic [tsrr_pkg::TID_W-1:0]       tid_q   [tsrr_pkg::SLOT_COUNT];
	logic                             fresh_q [tsrr_pkg::SLOT_COUNT];

	// Update all slots: wake sleepers, then apply the indexed write on top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tsrr_pkg::SLOT_COUNT; i++) begin
				state_q[i] <= (i == 0) ? tsrr_pkg::SLOT_RUNNING : tsrr_pkg::SLOT_FREE;
				tid_q[i]   <= (i == 0) ? '0 : '1;
				fresh_q[i] <= 1'b0;
			end
		end else begin
			for (int i = 0; i < tsrr_pkg::SLOT_COUNT; i++) begin
				if (cmd.state_en && cmd.idx == tsrr_pkg::SLOT_W'(i)) begin
					state_q[i] <= cmd.state_val;
				end else if (cmd.wake && state_q[i] == tsrr_pkg::SLOT_SLEEPING) begin
					state_q[i] <= tsrr_pkg::SLOT_RUNNABLE;
				end
				if (cmd.tid_en && cmd.idx == tsrr_pkg::SLOT_W'(i)) begin
					tid_q[i] <= cmd.tid_val;
				end
				if (cmd.fresh_en && cmd.idx == tsrr_pkg::SLOT_W'(i)) begin
					fresh_q[i] <= cmd.fresh_val;
				end
			end
		end
	end

	// Read the scanned slot and the running slot's tid
	always_comb begin
		rd.state = state_q[rd_idx];
		rd.tid   = tid_q[rd_idx];
		rd.fresh = fresh_q[rd_idx];
		cur_tid  = tid_q[cur_idx];
	end

endmodule

// File: src/tsrr_ctrl.sv
// Sequencer of the scheduler: one slot compare per cycle drives create,
// join lookup and the round-robin switch. Depends on tsrr_pkg, the slot
// table and two tsrr_ram instances (entry words and saved context).
module tsrr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsrr_pkg::in_item_t  in_item,
	input  logic                out_free,
	output logic                res_valid,
	output tsrr_pkg::out_item_t res_item
);

	tsrr_pkg::seq_state_t          state_q, state_d;
	tsrr_pkg::slot_idx_t           cur_q;
	tsrr_pkg::slot_idx_t           idx_q;
	logic [tsrr_pkg::TID_W-1:0]    next_tid_q;

	logic [tsrr_pkg::WORD_W-1:0]   start_q, arg_q, sp_q, fp_q;
	logic [tsrr_pkg::TID_W-1:0]    jt_q;
	tsrr_pkg::status_t             status_q;
	logic [tsrr_pkg::TID_W-1:0]    new_tid_q;
	logic                          switched_q;
	logic                          first_run_q;

	tsrr_pkg::tbl_cmd_t            cmd;
	tsrr_pkg::tbl_rd_t             rd;
	tsrr_pkg::slot_idx_t           rd_idx;
	logic [tsrr_pkg::TID_W-1:0]    cur_tid;

	logic                          ent_wr_en, ctx_wr_en, ram_rd_en;
	tsrr_pkg::slot_idx_t           ctx_wr_addr;
	logic [tsrr_pkg::PAIR_W-1:0]   ctx_wr_data;
	logic [tsrr_pkg::PAIR_W-1:0]   ent_rd_data, ctx_rd_data;

	logic                          accept;
	logic                          budget_ok, join_ok;
	logic                          hit, last;
	tsrr_pkg::op_t                 in_op;

	assign in_op     = tsrr_pkg::op_t'(in_item.op);
	assign accept    = in_valid && in_ready;
	assign budget_ok = next_tid_q <= tsrr_pkg::TID_W'(tsrr_pkg::SLOT_COUNT);
	assign join_ok   = in_item.join_tid < next_tid_q;

	tsrr_slot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_idx  (rd_idx),
		.cur_idx (cur_q),
		.rd      (rd),
		.cur_tid (cur_tid)
	);

	tsrr_ram #(
		.DEPTH (tsrr_pkg::SLOT_COUNT),
		.WIDTH (tsrr_pkg::PAIR_W)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ent_wr_en),
		.wr_addr (idx_q),
		.wr_data ({start_q, arg_q}),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ent_rd_data)
	);

	tsrr_ram #(
		.DEPTH (tsrr_pkg::SLOT_COUNT),
		.WIDTH (tsrr_pkg::PAIR_W)
	) u_ctx_ram (
		.clk     (clk),
		.wr_en   (ctx_wr_en),
		.wr_addr (ctx_wr_addr),
		.wr_data (ctx_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ctx_rd_data)
	);

	// Shared compare unit: the key depends on the scan being run
	always_comb begin
		hit  = 1'b0;
		last = (idx_q == tsrr_pkg::SLOT_W'(tsrr_pkg::SLOT_COUNT - 1));
		unique case (state_q)
			tsrr_pkg::SEQ_CREATE_SCAN: hit = (rd.state == tsrr_pkg::SLOT_FREE);
			tsrr_pkg::SEQ_JOIN_SCAN:   hit = (rd.tid == jt_q);
			tsrr_pkg::SEQ_SWITCH_SCAN: begin
				hit  = (rd.state == tsrr_pkg::SLOT_RUNNABLE);
				last = (idx_q == cur_q);
			end
			default: hit = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsrr_pkg::SEQ_IDLE: begin
				if (accept) begin
					unique case (in_op)
						tsrr_pkg::OP_CREATE:
							state_d = budget_ok ? tsrr_pkg::SEQ_CREATE_SCAN : tsrr_pkg::SEQ_DONE;
						tsrr_pkg::OP_JOIN:
							state_d = join_ok ? tsrr_pkg::SEQ_JOIN_SCAN : tsrr_pkg::SEQ_DONE;
						tsrr_pkg::OP_YIELD, tsrr_pkg::OP_EXIT:
							state_d = tsrr_pkg::SEQ_SAVE;
					endcase
				end
			end
			tsrr_pkg::SEQ_CREATE_SCAN: begin
				if (hit || last) begin
					state_d = tsrr_pkg::SEQ_DONE;
				end
			end
			tsrr_pkg::SEQ_JOIN_SCAN: begin
				priority if (hit) begin
					state_d = tsrr_pkg::SEQ_SAVE;
				end else if (last) begin
					state_d = tsrr_pkg::SEQ_DONE;
				end
			end
			tsrr_pkg::SEQ_SAVE: state_d = tsrr_pkg::SEQ_SWITCH_SCAN;
			tsrr_pkg::SEQ_SWITCH_SCAN: begin
				priority if (hit) begin
					state_d = tsrr_pkg::SEQ_FETCH;
				end else if (last) begin
					state_d = tsrr_pkg::SEQ_DONE;
				end
			end
			tsrr_pkg::SEQ_FETCH: state_d = tsrr_pkg::SEQ_DONE;
			tsrr_pkg::SEQ_DONE: begin
				if (out_free) begin
					state_d = tsrr_pkg::SEQ_IDLE;
				end
			end
			default: state_d = tsrr_pkg::SEQ_IDLE;
		endcase
	end

	// Outputs: table updates, RAM strobes and handshake
	always_comb begin
		cmd         = '0;
		cmd.idx     = idx_q;
		rd_idx      = idx_q;
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		ent_wr_en   = 1'b0;
		ctx_wr_en   = 1'b0;
		ctx_wr_addr = idx_q;
		ctx_wr_data = '0;
		ram_rd_en   = 1'b0;
		unique case (state_q)
			tsrr_pkg::SEQ_IDLE: begin
				in_ready = 1'b1;
				// Exit: free the caller and wake every sleeper
				if (in_valid && in_op == tsrr_pkg::OP_EXIT) begin
					cmd.idx       = cur_q;
					cmd.state_en  = 1'b1;
					cmd.state_val = tsrr_pkg::SLOT_FREE;
					cmd.wake      = 1'b1;
				end
			end
			tsrr_pkg::SEQ_CREATE_SCAN: begin
				if (hit) begin
					cmd.state_en  = 1'b1;
					cmd.state_val = tsrr_pkg::SLOT_RUNNABLE;
					cmd.tid_en    = 1'b1;
					cmd.tid_val   = next_tid_q;
					cmd.fresh_en  = 1'b1;
					cmd.fresh_val = 1'b1;
					ent_wr_en     = 1'b1;
					ctx_wr_en     = 1'b1;
				end
			end
			tsrr_pkg::SEQ_JOIN_SCAN: begin
				if (hit) begin
					cmd.idx       = cur_q;
					cmd.state_en  = 1'b1;
					cmd.state_val = tsrr_pkg::SLOT_SLEEPING;
				end
			end
			tsrr_pkg::SEQ_SAVE: begin
				// Demote the caller if it is still running and store its context
				rd_idx        = cur_q;
				cmd.idx       = cur_q;
				cmd.state_en  = (rd.state == tsrr_pkg::SLOT_RUNNING);
				cmd.state_val = tsrr_pkg::SLOT_RUNNABLE;
				ctx_wr_en     = 1'b1;
				ctx_wr_addr   = cur_q;
				ctx_wr_data   = {sp_q, fp_q};
			end
			tsrr_pkg::SEQ_SWITCH_SCAN: begin
				if (hit) begin
					cmd.state_en  = 1'b1;
					cmd.state_val = tsrr_pkg::SLOT_RUNNING;
					cmd.fresh_en  = rd.fresh;
					cmd.fresh_val = 1'b0;
					ram_rd_en     = 1'b1;
				end
			end
			tsrr_pkg::SEQ_FETCH: ram_rd_en = 1'b0;
			tsrr_pkg::SEQ_DONE:  res_valid = 1'b1;
			default:             res_valid = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tsrr_pkg::SEQ_IDLE;
			cur_q      <= '0;
			next_tid_q <= tsrr_pkg::TID_W'(1);
		end else begin
			state_q <= state_d;
			if (state_q == tsrr_pkg::SEQ_CREATE_SCAN && hit) begin
				next_tid_q <= next_tid_q + 1'b1;
			end
			if (state_q == tsrr_pkg::SEQ_SWITCH_SCAN && hit) begin
				cur_q <= idx_q;
			end
		end
	end

	// Item and scan registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			tsrr_pkg::SEQ_IDLE: begin
				if (accept) begin
					start_q     <= in_item.start_address;
					arg_q       <= in_item.argument;
					jt_q        <= in_item.join_tid;
					sp_q        <= in_item.saved_sp;
					fp_q        <= in_item.saved_fp;
					idx_q       <= '0;
					new_tid_q   <= '0;
					switched_q  <= 1'b0;
					first_run_q <= 1'b0;
					priority if (in_op == tsrr_pkg::OP_CREATE && !budget_ok) begin
						status_q <= tsrr_pkg::STATUS_REFUSED;
					end else if (in_op == tsrr_pkg::OP_JOIN && !join_ok) begin
						status_q <= tsrr_pkg::STATUS_BAD_JOIN;
					end else begin
						status_q <= tsrr_pkg::STATUS_OK;
					end
				end
			end
			tsrr_pkg::SEQ_CREATE_SCAN: begin
				priority if (hit) begin
					new_tid_q <= next_tid_q;
				end else if (last) begin
					status_q <= tsrr_pkg::STATUS_REFUSED;
				end else begin
					idx_q <= tsrr_pkg::slot_inc(idx_q);
				end
			end
			tsrr_pkg::SEQ_JOIN_SCAN: begin
				if (!hit) begin
					idx_q <= tsrr_pkg::slot_inc(idx_q);
				end
			end
			tsrr_pkg::SEQ_SAVE: idx_q <= tsrr_pkg::slot_inc(cur_q);
			tsrr_pkg::SEQ_SWITCH_SCAN: begin
				priority if (hit) begin
					switched_q  <= 1'b1;
					first_run_q <= rd.fresh;
				end else if (last) begin
					status_q <= tsrr_pkg::STATUS_NO_RUN;
				end else begin
					idx_q <= tsrr_pkg::slot_inc(idx_q);
				end
			end
			default: ;
		endcase
	end

	// Assemble the result; resume words come from the chosen slot's RAM rows
	always_comb begin
		res_item                 = '0;
		res_item.status          = status_q;
		res_item.new_tid         = new_tid_q;
		res_item.running_tid     = cur_tid;
		res_item.running_slot    = tsrr_pkg::SLOT_OUT_W'(cur_q);
		res_item.first_run       = switched_q && first_run_q;
		if (switched_q && first_run_q) begin
			res_item.resume_start    = ent_rd_data[tsrr_pkg::PAIR_W-1:tsrr_pkg::WORD_W];
			res_item.resume_argument = ent_rd_data[tsrr_pkg::WORD_W-1:0];
		end
		if (switched_q && !first_run_q) begin
			res_item.resume_sp = ctx_rd_data[tsrr_pkg::PAIR_W-1:tsrr_pkg::WORD_W];
			res_item.resume_fp = ctx_rd_data[tsrr_pkg::WORD_W-1:0];
		end
	end

endmodule

// File: tb/thread_slot_round_robin_scheduler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the round-robin thread slot scheduler: a directed call table,
// then random call traffic, checked against a slot table model kept here or the typed results.
// Depends on tsrr_pkg and the thread_slot_round_robin_scheduler top level only.
module thread_slot_round_robin_scheduler_test;
	import tsrr_pkg::*;

	localparam int unsigned QUIET_LIMIT   = 1000;
	localparam int unsigned HOLD_CYCLES   = 250;
	localparam int unsigned RANDOM_CALLS  = 1000;
	localparam int unsigned SETTLE_CYCLES = 2 * SLOT_COUNT + 24;

	// One directed call: the request, and the result where it is typed in by hand.
	typedef struct packed {
		in_item_t  stim;
		logic      typed;
		out_item_t want;
	} call_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	// Slot table as the scheduler should hold it after every accepted call.
	slot_state_t       sched_state [SLOT_COUNT];
	logic [TID_W-1:0]  sched_tid   [SLOT_COUNT];
	logic [WORD_W-1:0] sched_entry [SLOT_COUNT];
	logic [WORD_W-1:0] sched_arg   [SLOT_COUNT];
	logic [WORD_W-1:0] sched_sp    [SLOT_COUNT];
	logic [WORD_W-1:0] sched_fp    [SLOT_COUNT];
	logic              sched_fresh [SLOT_COUNT];
	int unsigned       sched_cur;
	int unsigned       sched_next_tid;

	out_item_t   sched_expect_q[$];
	call_row_t   call_rows[$];
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned fresh_starts = 0;
	int unsigned refusals = 0;
	int unsigned bad_joins = 0;
	int unsigned idle_results = 0;
	int unsigned calls_sent = 0;
	int unsigned hold_reqs = 0;
	int unsigned quiet_cycles = 0;

	thread_slot_round_robin_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic in_item_t stim(input op_t op, input logic [WORD_W-1:0] entry,
			input logic [WORD_W-1:0] arg, input logic [TID_W-1:0] jt,
			input logic [WORD_W-1:0] sp, input logic [WORD_W-1:0] fp);
		in_item_t it;
		it.op            = op;
		it.start_address = entry;
		it.argument      = arg;
		it.join_tid      = jt;
		it.saved_sp      = sp;
		it.saved_fp      = fp;
		return it;
	endfunction

	function automatic out_item_t res(input status_t st, input logic [TID_W-1:0] nt,
			input logic [TID_W-1:0] rt, input logic [SLOT_OUT_W-1:0] rs, input logic fr,
			input logic [WORD_W-1:0] rst, input logic [WORD_W-1:0] rarg,
			input logic [WORD_W-1:0] rsp, input logic [WORD_W-1:0] rfp);
		out_item_t r;
		r.status          = st;
		r.new_tid         = nt;
		r.running_tid     = rt;
		r.running_slot    = rs;
		r.first_run       = fr;
		r.resume_start    = rst;
		r.resume_argument = rarg;
		r.resume_sp       = rsp;
		r.resume_fp       = rfp;
		return r;
	endfunction

	function automatic int unsigned live_slots();
		int unsigned n;
		n = 0;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (sched_state[i] != SLOT_FREE) n++;
		return n;
	endfunction

	// Save the caller's context and hand the slot to the next runnable one, wrapping
	// around so the caller itself is looked at last.
	function automatic out_item_t rotate_to_runnable(input logic [WORD_W-1:0] sp,
			input logic [WORD_W-1:0] fp);
		out_item_t   r;
		int unsigned base;
		int unsigned j;
		bit          found;
		r = '0;
		r.status = STATUS_NO_RUN;
		found = 1'b0;
		base = sched_cur;
		if (sched_state[base] == SLOT_RUNNING) sched_state[base] = SLOT_RUNNABLE;
		sched_sp[base] = sp;
		sched_fp[base] = fp;
		for (int k = 1; k <= SLOT_COUNT; k++) begin
			j = (base + k) % SLOT_COUNT;
			if (!found && sched_state[j] == SLOT_RUNNABLE) begin
				found = 1'b1;
				r.status = STATUS_OK;
				sched_cur = j;
				sched_state[j] = SLOT_RUNNING;
				if (sched_fresh[j]) begin
					sched_fresh[j] = 1'b0;
					r.first_run = 1'b1;
					r.resume_start = sched_entry[j];
					r.resume_argument = sched_arg[j];
				end else begin
					r.resume_sp = sched_sp[j];
					r.resume_fp = sched_fp[j];
				end
			end
		end
		return r;
	endfunction

	// Apply one scheduler call to the slot table and return the result it must give.
	function automatic out_item_t schedule_call(input in_item_t it);
		out_item_t r;
		bit        found;
		r = '0;
		found = 1'b0;
		case (op_t'(it.op))
			OP_CREATE: begin
				r.status = STATUS_REFUSED;
				if (sched_next_tid <= SLOT_COUNT) begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (!found && sched_state[i] == SLOT_FREE) begin
							found = 1'b1;
							sched_tid[i] = TID_W'(sched_next_tid);
							sched_entry[i] = it.start_address;
							sched_arg[i] = it.argument;
							sched_sp[i] = '0;
							sched_fp[i] = '0;
							sched_fresh[i] = 1'b1;
							sched_state[i] = SLOT_RUNNABLE;
							r.new_tid = TID_W'(sched_next_tid);
							r.status = STATUS_OK;
							sched_next_tid++;
						end
					end
				end
			end
			OP_YIELD: r = rotate_to_runnable(it.saved_sp, it.saved_fp);
			OP_JOIN: begin
				if (int'(it.join_tid) >= int'(sched_next_tid)) begin
					r.status = STATUS_BAD_JOIN;
				end else begin
					// stale tids still match: the slot keeps its tid after exit
					for (int i = 0; i < SLOT_COUNT; i++)
						if (sched_tid[i] == it.join_tid) found = 1'b1;
					if (found) begin
						sched_state[sched_cur] = SLOT_SLEEPING;
						r = rotate_to_runnable(it.saved_sp, it.saved_fp);
					end
				end
			end
			OP_EXIT: begin
				sched_state[sched_cur] = SLOT_FREE;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (sched_state[i] == SLOT_SLEEPING) sched_state[i] = SLOT_RUNNABLE;
					if (sched_state[i] != SLOT_FREE) found = 1'b1;
				end
				if (found) begin
					r = rotate_to_runnable(it.saved_sp, it.saved_fp);
				end else begin
					sched_sp[sched_cur] = it.saved_sp;
					sched_fp[sched_cur] = it.saved_fp;
					r.status = STATUS_NO_RUN;
				end
			end
		endcase
		r.running_tid = sched_tid[sched_cur];
		r.running_slot = SLOT_OUT_W'(sched_cur);
		return r;
	endfunction

	// Random call with the op weighted by the table: mostly yields and joins that keep
	// threads alive, rare exits, and exits favored once every thread sleeps.
	function automatic in_item_t random_call();
		in_item_t    it;
		int unsigned ready_cnt;
		int unsigned roll;
		bit          stuck;
		ready_cnt = 0;
		stuck = 1'b1;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (sched_state[i] == SLOT_RUNNING) stuck = 1'b0;
			if (sched_state[i] == SLOT_RUNNABLE) ready_cnt++;
		end
		it.start_address = $urandom();
		it.argument = $urandom();
		it.saved_sp = $urandom();
		it.saved_fp = $urandom();
		if ($urandom_range(4) != 0)
			it.join_tid = TID_W'($urandom_range(sched_next_tid - 1));
		else
			it.join_tid = TID_W'($urandom_range(255));
		roll = $urandom_range(199);
		if (roll < 16)
			it.op = OP_CREATE;
		else if (stuck ? roll < 60 : (live_slots() >= 4 && roll < 19))
			it.op = OP_EXIT;
		else if (roll < (ready_cnt != 0 ? 90 : 20))
			it.op = OP_JOIN;
		else
			it.op = OP_YIELD;
		return it;
	endfunction

	// Offer one call, wait for its transfer and log what it must return.
	// Entered and left at a falling edge.
	task automatic send_call(input in_item_t it, input logic typed, input out_item_t want,
			input int unsigned gap);
		out_item_t pred;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		pred = schedule_call(it);
		sched_expect_q.push_back(typed ? want : pred);
		calls_sent++;
		@(negedge clk);
	endtask

	task automatic cmp_field(input string fname, input logic [WORD_W-1:0] want_v,
			input logic [WORD_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", fname, want_v, got_v);
			mismatches++;
		end
	endtask

	// Check every result transfer against the oldest outstanding call.
	always @(posedge clk) begin
		out_item_t due;
		if (arst_n && out_valid && out_ready) begin
			if (sched_expect_q.size() == 0) begin
				$error("result with no call outstanding: %h", out_item);
				mismatches++;
			end else begin
				due = sched_expect_q.pop_front();
				cmp_field("status", due.status, out_item.status);
				cmp_field("new_tid", due.new_tid, out_item.new_tid);
				cmp_field("running_tid", due.running_tid, out_item.running_tid);
				cmp_field("running_slot", due.running_slot, out_item.running_slot);
				cmp_field("first_run", due.first_run, out_item.first_run);
				cmp_field("resume_start", due.resume_start, out_item.resume_start);
				cmp_field("resume_argument", due.resume_argument, out_item.resume_argument);
				cmp_field("resume_sp", due.resume_sp, out_item.resume_sp);
				cmp_field("resume_fp", due.resume_fp, out_item.resume_fp);
				results_checked++;
				if (due.first_run) fresh_starts++;
				if (due.status == STATUS_REFUSED) refusals++;
				if (due.status == STATUS_BAD_JOIN) bad_joins++;
				if (due.status == STATUS_NO_RUN) idle_results++;
			end
		end
	end

	// Abort when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$error("no transfer for %0d cycles, %0d results outstanding", QUIET_LIMIT,
				sched_expect_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random stall before each transfer, bursts with no stall, and one
	// long hold-off on request from the call side.
	initial begin
		int unsigned stall;
		int unsigned holds_done;
		int unsigned rx_n;
		holds_done = 0;
		rx_n = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = (rx_n % 230 < 40) ? 0 : $urandom_range(14);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			rx_n++;
		end
	end

	// Call side and run control.
	initial begin
		in_item_t    it;
		int unsigned gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;

		// table after reset: slot 0 runs tid 0, every other slot free
		for (int i = 0; i < SLOT_COUNT; i++) begin
			sched_state[i] = SLOT_FREE;
			sched_tid[i] = '1;
			sched_entry[i] = '0;
			sched_arg[i] = '0;
			sched_sp[i] = '0;
			sched_fp[i] = '0;
			sched_fresh[i] = 1'b0;
		end
		sched_state[0] = SLOT_RUNNING;
		sched_tid[0] = '0;
		sched_cur = 0;
		sched_next_tid = 1;

		// lone slot 0 yields back to itself; joins on tids not yet given out are refused
		call_rows.push_back('{stim(OP_YIELD, $urandom(), $urandom(), 8'd0, '1, '0), 1'b1,
			res(STATUS_OK, 0, 0, 0, 0, 0, 0, '1, '0)});
		call_rows.push_back('{stim(OP_JOIN, $urandom(), $urandom(), 8'd1, '0, '1), 1'b1,
			res(STATUS_BAD_JOIN, 0, 0, 0, 0, 0, 0, 0, 0)});
		call_rows.push_back('{stim(OP_JOIN, '0, '1, '1, $urandom(), $urandom()), 1'b1,
			res(STATUS_BAD_JOIN, 0, 0, 0, 0, 0, 0, 0, 0)});
		// fill the table, then one create too many
		call_rows.push_back('{stim(OP_CREATE, '1, '0, '0, $urandom(), $urandom()), 1'b1,
			res(STATUS_OK, 1, 0, 0, 0, 0, 0, 0, 0)});
		call_rows.push_back('{stim(OP_CREATE, '0, '1, '1, $urandom(), $urandom()), 1'b1,
			res(STATUS_OK, 2, 0, 0, 0, 0, 0, 0, 0)});
		for (int i = 0; i < SLOT_COUNT - 3; i++)
			call_rows.push_back('{stim(OP_CREATE, $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom()), 1'b0, out_item_t'('0)});
		call_rows.push_back('{stim(OP_CREATE, $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom()), 1'b1, res(STATUS_REFUSED, 0, 0, 0, 0, 0, 0, 0, 0)});
		// first switch starts slot 1 fresh from its entry word
		call_rows.push_back('{stim(OP_YIELD, $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom()), 1'b1, res(STATUS_OK, 0, 1, 1, 1, '1, '0, 0, 0)});
		// join live tid 0, exit, join the exited tid, reuse the freed slot with the
		// last tid, create past the tid budget, join a tid no slot holds any more
		call_rows.push_back('{stim(OP_JOIN, $urandom(), $urandom(), 8'd0,
			$urandom(), $urandom()), 1'b0, out_item_t'('0)});
		call_rows.push_back('{stim(OP_EXIT, $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom()), 1'b0, out_item_t'('0)});
		call_rows.push_back('{stim(OP_JOIN, $urandom(), $urandom(), 8'd2,
			$urandom(), $urandom()), 1'b0, out_item_t'('0)});
		call_rows.push_back('{stim(OP_CREATE, $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom()), 1'b0, out_item_t'('0)});
		call_rows.push_back('{stim(OP_CREATE, $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom()), 1'b0, out_item_t'('0)});
		call_rows.push_back('{stim(OP_JOIN, $urandom(), $urandom(), 8'd2,
			$urandom(), $urandom()), 1'b0, out_item_t'('0)});
		call_rows.push_back('{stim(OP_JOIN, $urandom(), $urandom(), 8'(SLOT_COUNT),
			$urandom(), $urandom()), 1'b0, out_item_t'('0)});
		call_rows.push_back('{stim(OP_YIELD, $urandom(), $urandom(), $urandom(),
			$urandom(), '1), 1'b0, out_item_t'('0)});

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (call_rows[n])
			send_call(call_rows[n].stim, call_rows[n].typed, call_rows[n].want,
				$urandom_range(14));

		// drain the directed calls before random traffic
		in_valid <= 1'b0;
		do @(negedge clk); while (sched_expect_q.size() != 0);

		for (int n = 0; n < RANDOM_CALLS; n++) begin
			if (n == 300) hold_reqs++;
			gap = (n % 250 < 40) ? 0 : $urandom_range(14);
			it = random_call();
			send_call(it, 1'b0, '0, gap);
		end

		// drain, then retire every thread and poke the empty table with each op
		in_valid <= 1'b0;
		do @(negedge clk); while (sched_expect_q.size() != 0);
		for (int k = 0; k < 2 * SLOT_COUNT && live_slots() != 0; k++)
			send_call(stim(OP_EXIT, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom()), 1'b0, '0, $urandom_range(14));
		for (int k = 0; k < 8; k++) begin
			it = random_call();
			it.op = op_t'(k % 4);
			send_call(it, 1'b0, '0, $urandom_range(14));
		end

		in_valid <= 1'b0;
		while (sched_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sched_expect_q.size() != 0)
			$error("%0d results never arrived", sched_expect_q.size());
		$display("%0d scheduler calls sent, %0d results checked", calls_sent,
			results_checked);
		$display("fresh starts %0d, refused creates %0d, bad joins %0d, nothing runnable %0d",
			fresh_starts, refusals, bad_joins, idle_results);
		if (mismatches == 0 && sched_expect_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
